// ===== rtl/core/velocity_magnitude_clamp_core_defines.svh =====
// ----------------------------------------------------------------------------
// Velocity magnitude clamp assertion macros
// Shared property forms for the checker of the clamp core.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_MAGNITUDE_CLAMP_CORE_DEFINES_SVH
`define VELOCITY_MAGNITUDE_CLAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define VMC_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity magnitude clamp package
// Widths, register codes and cell state types shared by the clamp core.
// ----------------------------------------------------------------------------
`default_nettype none

package vmc_pkg;

    localparam int CW       = 32;              // component width
    localparam int FB       = 16;              // fraction bits
    localparam int CAP_W    = 31;
    localparam int BLEND_W  = 17;
    localparam int BLEND_FB = 16;
    localparam int SQ_W     = 2 * CW;
    localparam int RAD_W    = SQ_W + 2;        // sum of three squares
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_SQ_W = ROOT_W + 2;
    localparam int CAPSQ_W  = 2 * CAP_W;
    localparam int CMP_W    = (RAD_W > CAPSQ_W) ? RAD_W : CAPSQ_W;
    localparam int PROD_W   = CW + ROOT_W;
    localparam int TDATA_W  = ((3 * CW + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - 3 * CW;

    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(10) << FB;
    localparam logic [BLEND_W-1:0] BLEND_RESET = BLEND_W'(64225);
    localparam logic [BLEND_W-1:0] BLEND_ONE   = BLEND_W'(1) << BLEND_FB;

    typedef enum logic [1:0] {
        REG_SPEED_CAP  = 2'd0,
        REG_SOFT_MODE  = 2'd1,
        REG_SOFT_BLEND = 2'd2
    } vmc_reg_t;

    typedef struct packed {
        logic [REM_SQ_W-1:0]  rem;
        logic [ROOT_W-1:0]    root;
        logic [RAD_W-1:0]     rad;
        logic [2:0][CW-1:0]   mag;
        logic [2:0]           neg;
        logic                 limited;
    } vmc_sqrt_t;

    typedef struct packed {
        logic [ROOT_W-1:0]        dvsr;
        logic [2:0][ROOT_W-1:0]   rem;
        logic [2:0][CW-1:0]       nq;
        logic [2:0]               neg;
        logic                     limited;
    } vmc_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/vmc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Decides one root bit from two radicand bits and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_sqrt_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire vmc_pkg::vmc_sqrt_t in_cell,
    output logic                   out_valid,
    output vmc_pkg::vmc_sqrt_t     out_cell
);

    logic [vmc_pkg::REM_SQ_W+1:0] rem_t;
    logic [vmc_pkg::REM_SQ_W+1:0] trial;
    vmc_pkg::vmc_sqrt_t           cell_next;

    always_comb begin
        rem_t     = {in_cell.rem, in_cell.rad[vmc_pkg::RAD_W-1 -: 2]};
        trial     = (vmc_pkg::REM_SQ_W+2)'({in_cell.root, 2'b01});
        cell_next = in_cell;
        cell_next.rad = in_cell.rad << 2;
        if (rem_t >= trial) begin
            cell_next.rem  = vmc_pkg::REM_SQ_W'(rem_t - trial);
            cell_next.root = {in_cell.root[vmc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = vmc_pkg::REM_SQ_W'(rem_t);
            cell_next.root = {in_cell.root[vmc_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_cell <= cell_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vmc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit for each of the three lanes and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_div_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire vmc_pkg::vmc_div_t in_cell,
    output logic                  out_valid,
    output vmc_pkg::vmc_div_t     out_cell
);

    logic [vmc_pkg::ROOT_W:0] dv;
    logic [vmc_pkg::ROOT_W:0] t;
    vmc_pkg::vmc_div_t        cell_next;

    always_comb begin
        dv        = {1'b0, in_cell.dvsr};
        t         = '0;
        cell_next = in_cell;
        for (int i = 0; i < 3; i++) begin
            t = {in_cell.rem[i], in_cell.nq[i][vmc_pkg::CW-1]};
            if (t >= dv) begin
                cell_next.rem[i] = vmc_pkg::ROOT_W'(t - dv);
                cell_next.nq[i]  = {in_cell.nq[i][vmc_pkg::CW-2:0], 1'b1};
            end else begin
                cell_next.rem[i] = t[vmc_pkg::ROOT_W-1:0];
                cell_next.nq[i]  = {in_cell.nq[i][vmc_pkg::CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_cell <= cell_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/velocity_magnitude_clamp_core.sv =====
// Throughput: one word per cycle unless the sink stalls the output; the
// square root chain and the divider chain each retire one bit per cell,
// so neither limits the rate.
// Backpressure stalls the whole pipeline in lockstep through one advance.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// registers with cap 10.0, hard mode and blend 64225.
// ----------------------------------------------------------------------------
// Velocity magnitude clamp core
// Limits the length of a signed fixed-point 3-D velocity to a programmable
// cap, either hard or with a soft blend toward the cap.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_magnitude_clamp_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input word: vel_x, vel_y, vel_z (from bit 0 up), zero padded
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [vmc_pkg::TDATA_W-1:0] s_tdata,
    // output word: out_x, out_y, out_z (from bit 0 up), zero padded
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vmc_pkg::TDATA_W-1:0]      m_tdata,
    // was_limited
    output logic [0:0]                       m_tuser
);

    localparam int CW     = vmc_pkg::CW;
    localparam int ROOT_W = vmc_pkg::ROOT_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [vmc_pkg::CAP_W-1:0]   cap_reg;
    logic                        mode_reg;
    logic [vmc_pkg::BLEND_W-1:0] blend_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= vmc_pkg::CAP_RESET;
            mode_reg  <= 1'b0;
            blend_reg <= vmc_pkg::BLEND_RESET;
        end else if (wr_en) begin
            case (vmc_pkg::vmc_reg_t'(paddr[3:2]))
                vmc_pkg::REG_SPEED_CAP:  cap_reg   <= pwdata[vmc_pkg::CAP_W-1:0];
                vmc_pkg::REG_SOFT_MODE:  mode_reg  <= pwdata[0];
                vmc_pkg::REG_SOFT_BLEND: blend_reg <= pwdata[vmc_pkg::BLEND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (vmc_pkg::vmc_reg_t'(paddr[3:2]))
            vmc_pkg::REG_SPEED_CAP:  prdata = 32'(cap_reg);
            vmc_pkg::REG_SOFT_MODE:  prdata = 32'(mode_reg);
            vmc_pkg::REG_SOFT_BLEND: prdata = 32'(blend_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output slot frees up
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: split sign and magnitude
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic [2:0][CW-1:0]   mag1_reg;
    logic [2:0]           neg1_reg;
    logic [2:0][CW-1:0]   mag1_next;
    logic [2:0]           neg1_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg1_next[i] = s_tdata[i*CW + CW-1];
            mag1_next[i] = neg1_next[i] ? (~s_tdata[i*CW +: CW] + 1'b1)
                                        : s_tdata[i*CW +: CW];
        end
    end

    // Stage 2: squares.  Stage 3: sum of squares.
    logic                           v2_reg, v3_reg;
    logic [2:0][CW-1:0]             mag2_reg, mag3_reg;
    logic [2:0]                     neg2_reg, neg3_reg;
    logic [2:0][vmc_pkg::SQ_W-1:0]  sq2_reg;
    logic [vmc_pkg::CAPSQ_W-1:0]    capsq2_reg, capsq3_reg;
    logic [vmc_pkg::RAD_W-1:0]      sum3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= vmc_pkg::SQ_W'(mag1_reg[i]) * vmc_pkg::SQ_W'(mag1_reg[i]);
            end
            capsq2_reg <= vmc_pkg::CAPSQ_W'(cap_reg) * vmc_pkg::CAPSQ_W'(cap_reg);
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            sum3_reg   <= vmc_pkg::RAD_W'(sq2_reg[0]) + vmc_pkg::RAD_W'(sq2_reg[1])
                        + vmc_pkg::RAD_W'(sq2_reg[2]);
            capsq3_reg <= capsq2_reg;
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain: one root bit per cell; the cap compare rides
    // into the first cell alongside the radicand
    // ------------------------------------------------------------------
    vmc_pkg::vmc_sqrt_t sq_cell [ROOT_W+1];
    logic               sq_v    [ROOT_W+1];

    always_comb begin
        sq_cell[0].rem     = '0;
        sq_cell[0].root    = '0;
        sq_cell[0].rad     = sum3_reg;
        sq_cell[0].mag     = mag3_reg;
        sq_cell[0].neg     = neg3_reg;
        sq_cell[0].limited = vmc_pkg::CMP_W'(sum3_reg) > vmc_pkg::CMP_W'(capsq3_reg);
        sq_v[0]            = v3_reg;
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        vmc_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (sq_v[g]),
            .in_cell   (sq_cell[g]),
            .out_valid (sq_v[g+1]),
            .out_cell  (sq_cell[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Target speed: difference, blend product, target, component products
    // ------------------------------------------------------------------
    vmc_pkg::vmc_sqrt_t sqo;
    assign sqo = sq_cell[ROOT_W];

    logic [ROOT_W-1:0]            cap_r;
    logic [vmc_pkg::BLEND_W-1:0]  blend_clamped;
    assign cap_r         = ROOT_W'(cap_reg);
    assign blend_clamped = (blend_reg > vmc_pkg::BLEND_ONE) ? vmc_pkg::BLEND_ONE : blend_reg;

    logic                 v5_reg, v6_reg, v7_reg, v8_reg;
    logic [2:0][CW-1:0]   mag5_reg, mag6_reg, mag7_reg;
    logic [2:0]           neg5_reg, neg6_reg, neg7_reg, neg8_reg;
    logic                 lim5_reg, lim6_reg, lim7_reg, lim8_reg;
    logic [ROOT_W-1:0]    speed5_reg, speed6_reg, speed7_reg, speed8_reg;
    logic [ROOT_W-1:0]    diff5_reg, step6_reg, target7_reg;
    logic [ROOT_W-1:0]    speed5_next, target7_next;
    logic [ROOT_W+vmc_pkg::BLEND_W-1:0]    blend_prod;
    logic [2:0][vmc_pkg::PROD_W-1:0]       prod8_reg;

    // Pass-through words divide by one with a target of one
    assign speed5_next  = sqo.limited ? sqo.root : ROOT_W'(1);
    assign blend_prod   = (ROOT_W+vmc_pkg::BLEND_W)'(diff5_reg)
                        * (ROOT_W+vmc_pkg::BLEND_W)'(blend_clamped);
    assign target7_next = !lim6_reg ? ROOT_W'(1) :
                          mode_reg  ? (speed6_reg - step6_reg) : cap_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= sq_v[ROOT_W];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            speed5_reg  <= speed5_next;
            diff5_reg   <= sqo.root - cap_r;
            mag5_reg    <= sqo.mag;
            neg5_reg    <= sqo.neg;
            lim5_reg    <= sqo.limited;

            step6_reg   <= ROOT_W'(blend_prod >> vmc_pkg::BLEND_FB);
            speed6_reg  <= speed5_reg;
            mag6_reg    <= mag5_reg;
            neg6_reg    <= neg5_reg;
            lim6_reg    <= lim5_reg;

            target7_reg <= target7_next;
            speed7_reg  <= speed6_reg;
            mag7_reg    <= mag6_reg;
            neg7_reg    <= neg6_reg;
            lim7_reg    <= lim6_reg;

            for (int i = 0; i < 3; i++) begin
                prod8_reg[i] <= vmc_pkg::PROD_W'(mag7_reg[i])
                              * vmc_pkg::PROD_W'(target7_reg);
            end
            speed8_reg  <= speed7_reg;
            neg8_reg    <= neg7_reg;
            lim8_reg    <= lim7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell, three lanes per cell
    // ------------------------------------------------------------------
    vmc_pkg::vmc_div_t dv_cell [CW+1];
    logic              dv_v    [CW+1];

    always_comb begin
        dv_cell[0].dvsr    = speed8_reg;
        dv_cell[0].neg     = neg8_reg;
        dv_cell[0].limited = lim8_reg;
        for (int i = 0; i < 3; i++) begin
            dv_cell[0].rem[i] = prod8_reg[i][vmc_pkg::PROD_W-1 -: ROOT_W];
            dv_cell[0].nq[i]  = prod8_reg[i][CW-1:0];
        end
        dv_v[0] = v8_reg;
    end

    for (genvar g = 0; g < CW; g++) begin : g_div
        vmc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (dv_v[g]),
            .in_cell   (dv_cell[g]),
            .out_valid (dv_v[g+1]),
            .out_cell  (dv_cell[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: restore signs, hold while the sink stalls
    // ------------------------------------------------------------------
    vmc_pkg::vmc_div_t   dvo;
    logic [3*CW-1:0]     out_next;
    logic [3*CW-1:0]     out_reg;
    logic                lim_out_reg;

    assign dvo = dv_cell[CW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_next[i*CW +: CW] = dvo.neg[i] ? (~dvo.nq[i] + 1'b1) : dvo.nq[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_v[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg     <= out_next;
            lim_out_reg <= dvo.limited;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{vmc_pkg::PAD_W{1'b0}}, out_reg};
    assign m_tuser[0] = lim_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vmc_checker.sv =====
// ----------------------------------------------------------------------------
// Velocity magnitude clamp checker
// Port-level properties of the clamp core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "velocity_magnitude_clamp_core_defines.svh"

module vmc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [vmc_pkg::TDATA_W-1:0] m_tdata,
    input wire logic [0:0]                  m_tuser,
    input wire logic                        pready
);

    // Reset empties the output slot
    `VMC_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "output valid after reset")
    // A stalled output word holds
    `VMC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")
    // A stalled output freezes the whole pipeline, so no input is taken
    `VMC_ASSERT_NOW(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
    // Free output slot always lets the pipeline advance
    `VMC_ASSERT_NOW(a_free_in, !m_tvalid, s_tready && pready, "input blocked with empty output")

endmodule

bind velocity_magnitude_clamp_core vmc_checker u_vmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
